/* hw/rtl/mcd_pkg.sv */
package mcd_pkg;

  localparam int DEPTH       = 16;
  localparam int QUEUE_COUNT = 4;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int QSEL_W      = $clog2(QUEUE_COUNT);
  localparam int ADDR_W      = QSEL_W + PTR_W;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int WORD_W      = 32;

  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_REFUSED   = 2'd3
  } status_t;

  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_MODES    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t                 operation;
    logic [1:0]          queue_select;
    logic signed [31:0]  push_value;
  } cmd_t;

  typedef struct packed {
    status_t             status;
    logic signed [31:0]  popped_value;
    logic [4:0]          occupancy;
  } result_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] occupancy;
    logic             pop_valid;
  } resp_t;

endpackage

/* hw/rtl/mcd_entry_ram.sv */
module mcd_entry_ram (
  input  logic                           clk,
  input  mcd_pkg::ram_req_t              req,
  output logic [mcd_pkg::WORD_W-1:0]     rdata
);
  import mcd_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH*QUEUE_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

/* hw/rtl/mcd_engine.sv */
module mcd_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  mcd_pkg::cmd_t                cmd,
  input  logic [mcd_pkg::CNT_W-1:0]    cap,
  input  logic [mcd_pkg::QUEUE_COUNT-1:0] modes,
  input  logic                         clear,
  output logic                         busy,
  output mcd_pkg::ram_req_t            ram_req,
  output logic                         done,
  output mcd_pkg::resp_t               resp
);
  import mcd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  op_t               op_r;
  logic [QSEL_W-1:0] q_r;
  logic [WORD_W-1:0] word_r;

  logic [PTR_W-1:0]       front_idx [QUEUE_COUNT];
  logic [PTR_W-1:0]       rear_idx  [QUEUE_COUNT];
  logic [QUEUE_COUNT-1:0] empty;

  logic [PTR_W-1:0] front, rear, front_next, rear_next, slot;
  logic             q_empty, empty_next, out_restr, refused, is_push, update;
  logic [CNT_W-1:0] occ, occ_next;
  status_t          status;
  logic             pop_ok;

  function automatic logic [PTR_W-1:0] step_up(logic [PTR_W-1:0] p, logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] s;
    s = CNT_W'(p) + CNT_W'(1);
    return (s >= c) ? '0 : s[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] step_down(logic [PTR_W-1:0] p, logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] m;
    m = c - CNT_W'(1);
    return (p == '0 || CNT_W'(p) >= c) ? m[PTR_W-1:0] : p - PTR_W'(1);
  endfunction

  assign busy = (state == S_EXEC);

  always_comb begin
    unique case (state)
      S_IDLE:  state_next = start ? S_EXEC : S_IDLE;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    front     = front_idx[q_r];
    rear      = rear_idx[q_r];
    q_empty   = empty[q_r];
    out_restr = modes[q_r];
    if (q_empty) begin
      occ = '0;
    end else if (rear >= front) begin
      occ = CNT_W'(rear) - CNT_W'(front) + CNT_W'(1);
    end else begin
      occ = CNT_W'(rear) + cap - CNT_W'(front) + CNT_W'(1);
    end
    refused = (op_r == OP_PUSH_FRONT && !out_restr) || (op_r == OP_POP_FRONT && out_restr);
    is_push = (op_r == OP_PUSH_REAR) || (op_r == OP_PUSH_FRONT);

    front_next = front;
    rear_next  = rear;
    empty_next = q_empty;
    slot       = front;
    status     = ST_DONE;
    occ_next   = occ;
    pop_ok     = 1'b0;
    update     = 1'b0;
    ram_req    = '{we: 1'b0, re: 1'b0, addr: '0, wdata: word_r};

    if (refused) begin
      status = ST_REFUSED;
    end else if (is_push) begin
      if (occ >= cap) begin
        status = ST_OVERFLOW;
      end else begin
        update   = 1'b1;
        occ_next = occ + CNT_W'(1);
        if (q_empty) begin
          front_next = '0;
          rear_next  = '0;
          empty_next = 1'b0;
          slot       = '0;
        end else if (op_r == OP_PUSH_REAR) begin
          rear_next = step_up(rear, cap);
          slot      = rear_next;
        end else begin
          front_next = step_down(front, cap);
          slot       = front_next;
        end
        ram_req.we = busy;
      end
    end else begin
      if (q_empty) begin
        status = ST_UNDERFLOW;
      end else begin
        update   = 1'b1;
        pop_ok   = 1'b1;
        occ_next = occ - CNT_W'(1);
        slot     = (op_r == OP_POP_FRONT) ? front : rear;
        if (front == rear) begin
          front_next = '0;
          rear_next  = '0;
          empty_next = 1'b1;
        end else if (op_r == OP_POP_FRONT) begin
          front_next = step_up(front, cap);
        end else begin
          rear_next = step_down(rear, cap);
        end
        ram_req.re = busy;
      end
    end
    ram_req.addr = {q_r, slot};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      empty <= '1;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        front_idx[i] <= '0;
        rear_idx[i]  <= '0;
      end
    end else begin
      state <= state_next;
      done  <= busy;
      if (clear) begin
        empty <= '1;
        for (int i = 0; i < QUEUE_COUNT; i++) begin
          front_idx[i] <= '0;
          rear_idx[i]  <= '0;
        end
      end else if (busy && update) begin
        front_idx[q_r] <= front_next;
        rear_idx[q_r]  <= rear_next;
        empty[q_r]     <= empty_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r   <= cmd.operation;
      q_r    <= cmd.queue_select[QSEL_W-1:0];
      word_r <= cmd.push_value;
    end
    if (busy) begin
      resp <= '{status: status, occupancy: occ_next, pop_valid: pop_ok};
    end
  end

endmodule

/* hw/rtl/multi_circular_deque.sv */
// Channel   Handshake            Payload
// command   start / busy         cmd       (operation, queue_select, push_value)
// result    done (one cycle)     result    (status, popped_value, occupancy)
// config    psel/penable/pwrite  paddr, pwdata, prdata; pready tied high
//
// An item is handled in steps: the engine reads the pointers, decides and
// accesses the entry RAM, then the registered RAM read returns. busy is high
// in the first; done follows in the next cycle, when a new command may be taken.
// Reset (rst, synchronous) empties every queue; no clearing pass is needed.
// The receiver cannot stall; results are never held.
module multi_circular_deque (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  mcd_pkg::cmd_t        cmd,
  output logic                 busy,
  output logic                 done,
  output mcd_pkg::result_t     result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import mcd_pkg::*;

  logic [4:0]             capacity_in_use;
  logic [QUEUE_COUNT-1:0] restriction_modes;
  logic [CNT_W-1:0]       cap;
  logic                   wr, clear;
  reg_idx_t               idx;
  ram_req_t               ram_req;
  logic [WORD_W-1:0]      ram_rdata;
  resp_t                  resp;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite && pready;
  assign clear  = wr && (idx == REG_CAPACITY);

  always_comb begin
    if (capacity_in_use == '0) begin
      cap = CNT_W'(1);
    end else if (capacity_in_use > 5'(DEPTH)) begin
      cap = CNT_W'(DEPTH);
    end else begin
      cap = CNT_W'(capacity_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use   <= 5'(DEPTH);
      restriction_modes <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_CAPACITY: capacity_in_use   <= pwdata[4:0];
        REG_MODES:    restriction_modes <= pwdata[QUEUE_COUNT-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CAPACITY: prdata = 32'(capacity_in_use);
      REG_MODES:    prdata = 32'(restriction_modes);
      default:      prdata = '0;
    endcase
  end

  mcd_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .cap     (cap),
    .modes   (restriction_modes),
    .clear   (clear),
    .busy    (busy),
    .ram_req (ram_req),
    .done    (done),
    .resp    (resp)
  );

  mcd_entry_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  always_comb begin
    result.status       = resp.status;
    result.popped_value = resp.pop_valid ? ram_rdata : '0;
    result.occupancy    = 5'(resp.occupancy);
  end

endmodule

/* hw/rtl/mcd_checker.sv */
module mcd_props (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input mcd_pkg::result_t     result
);
  import mcd_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("result did not follow the working cycle");

  a_done_unasked: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a command");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_DONE |-> result.popped_value == '0)
    else $error("refused operation returned a value");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_UNDERFLOW |-> result.occupancy == '0)
    else $error("underflow on a non-empty queue");

endmodule

bind multi_circular_deque mcd_props u_mcd_props (.*);
